// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the rasterizer RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge.
`define MCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true.
`define MCR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MCR_ASSERT(lbl, prop, msg)
`define MCR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/mcr_pkg.sv =====
`timescale 1ns / 1ps
package mcr_pkg;

  // Fixed field widths
  localparam int RADIUS_W    = 11;
  localparam int STEP_W      = 12;  // x / y offsets, radius plus one bit
  localparam int DEC_W       = 16;  // decision variable, signed
  localparam int IDX_W       = 3;   // point index within one iteration
  localparam int QUEUE_DEPTH = 2;

  // Request kind
  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_e;

  // Symmetry class of one iteration
  typedef enum logic [1:0] {
    SHAPE_SINGLE = 2'd0,  // x = y = 0: center only
    SHAPE_AXIS   = 2'd1,  // x = 0: four axis points
    SHAPE_DIAG   = 2'd2,  // x = y: four diagonal points
    SHAPE_FULL   = 2'd3   // eight points
  } shape_e;

  // One iteration handed from front to back
  typedef struct packed {
    logic [STEP_W-1:0] x;
    logic [STEP_W-1:0] y;
    shape_e            shape;
    logic              done;
  } step_t;

endpackage

// ===== rtl/mcr_in_if.sv =====
`timescale 1ns / 1ps
interface mcr_in_if #(
  parameter int COORD_WIDTH = 12
) ();
  logic                           valid;
  logic                           ready;
  mcr_pkg::kind_e                 kind;
  logic signed [COORD_WIDTH-1:0]  center_x;
  logic signed [COORD_WIDTH-1:0]  center_y;
  logic [mcr_pkg::RADIUS_W-1:0]   radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

// ===== rtl/mcr_out_if.sv =====
`timescale 1ns / 1ps
interface mcr_out_if #(
  parameter int COORD_WIDTH = 12
) ();
  logic                        valid;
  logic                        ready;
  logic signed [COORD_WIDTH:0] point_x;
  logic signed [COORD_WIDTH:0] point_y;
  logic                        last_of_step;
  logic                        circle_done;

  modport source (output valid, point_x, point_y, last_of_step, circle_done, input ready);
  modport sink   (input valid, point_x, point_y, last_of_step, circle_done, output ready);
endinterface

// ===== rtl/mcr_front.sv =====
`timescale 1ns / 1ps
module mcr_front #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mcr_in_if.sink                        item_i,
  input  logic                          full_i,
  output logic                          push_o,
  output mcr_pkg::step_t                step_o,
  output logic signed [COORD_WIDTH-1:0] cx_o,
  output logic signed [COORD_WIDTH-1:0] cy_o
);

  localparam int SW = mcr_pkg::STEP_W;
  localparam int DW = mcr_pkg::DEC_W;

  logic [SW-1:0]                 x_q, x_d, y_q, y_d, x_cur, y_cur;
  logic signed [DW-1:0]          d_q, d_d, d_cur, d_pos, d_neg;
  logic signed [COORD_WIDTH-1:0] cx_q, cx_d, cy_q, cy_d;
  logic                          running_q, running_d;
  logic                          fire, is_start;
  logic [SW:0]                   diff, x_n, y_n;
  logic                          done;

  assign item_i.ready = !full_i;
  assign fire         = item_i.valid && item_i.ready;
  assign is_start     = (item_i.kind == mcr_pkg::KIND_START);
  assign push_o       = fire && (is_start || running_q);

  // Operands of this iteration: fresh values on start, held values otherwise
  assign x_cur = is_start ? '0 : x_q;
  assign y_cur = is_start ? SW'(item_i.radius) : y_q;
  assign d_cur = is_start ? (DW'(3) - DW'({item_i.radius, 1'b0})) : d_q;
  assign cx_o  = is_start ? item_i.center_x : cx_q;
  assign cy_o  = is_start ? item_i.center_y : cy_q;

  // Midpoint update
  assign diff  = {1'b0, x_cur} - {1'b0, y_cur};
  assign d_pos = d_cur + DW'({x_cur, 2'b00}) + DW'(6);
  assign d_neg = d_cur + DW'($signed({diff, 2'b00})) + DW'(10);
  assign x_n   = {1'b0, x_cur} + (SW + 1)'(1);
  assign y_n   = d_cur[DW-1] ? {1'b0, y_cur} : ({1'b0, y_cur} - (SW + 1)'(1));
  assign done  = $signed(x_n) > $signed(y_n);

  // Classify symmetry of the current point pair
  always_comb begin
    step_o.x    = x_cur;
    step_o.y    = y_cur;
    step_o.done = done;
    priority if (x_cur == '0 && y_cur == '0) begin
      step_o.shape = mcr_pkg::SHAPE_SINGLE;
    end else if (x_cur == '0) begin
      step_o.shape = mcr_pkg::SHAPE_AXIS;
    end else if (x_cur == y_cur) begin
      step_o.shape = mcr_pkg::SHAPE_DIAG;
    end else begin
      step_o.shape = mcr_pkg::SHAPE_FULL;
    end
  end

  // Next state
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    d_d       = d_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    running_d = running_q;
    if (push_o) begin
      x_d       = x_n[SW-1:0];
      y_d       = y_n[SW-1:0];
      d_d       = d_cur[DW-1] ? d_pos : d_neg;
      cx_d      = cx_o;
      cy_d      = cy_o;
      running_d = !done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      d_q       <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      running_q <= 1'b0;
    end else begin
      x_q       <= x_d;
      y_q       <= y_d;
      d_q       <= d_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      running_q <= running_d;
    end
  end

endmodule

// ===== rtl/mcr_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcr_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `MCR_ASSERT(a_no_underflow, pop_i |-> count_q != '0, "queue popped while empty")
  `MCR_ASSERT(a_no_overflow, push_i |-> (!full_o || pop_i), "queue pushed while full")
  `MCR_ASSERT_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "queue count out of range")

endmodule

// ===== rtl/mcr_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcr_back #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  mcr_pkg::step_t                head_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  output logic                          pop_o,
  mcr_out_if.source                     point_o
);

  localparam int SW    = mcr_pkg::STEP_W;
  localparam int IW    = mcr_pkg::IDX_W;
  localparam int SUM_W = ((COORD_WIDTH > SW) ? COORD_WIDTH : SW) + 2;

  logic [IW-1:0]        idx_q, idx_d, last_idx, stride;
  logic                 out_valid_q, out_valid_d;
  logic [COORD_WIDTH:0] px_q, py_q;
  logic                 last_q, done_q;
  logic                 advance, load, is_last;
  logic [SW-1:0]        off_a, off_b;
  logic [SUM_W-1:0]     ext_a, ext_b, sum_x, sum_y;

  // Final index and index stride per symmetry class
  // Axis points visit 0, 2, 4, 5: up, down, right, left of the center
  always_comb begin
    unique case (head_i.shape)
      mcr_pkg::SHAPE_SINGLE: last_idx = IW'(0);
      mcr_pkg::SHAPE_AXIS:   last_idx = IW'(5);
      mcr_pkg::SHAPE_DIAG:   last_idx = IW'(3);
      mcr_pkg::SHAPE_FULL:   last_idx = IW'(7);
      default:               last_idx = IW'(7);
    endcase
  end
  assign stride  = ((head_i.shape == mcr_pkg::SHAPE_AXIS) && !idx_q[2]) ? IW'(2) : IW'(1);
  assign is_last = (idx_q == last_idx);

  // Octant point: bit 2 swaps x/y, bit 0 negates x offset, bit 1 negates y offset
  assign off_a = idx_q[2] ? head_i.y : head_i.x;
  assign off_b = idx_q[2] ? head_i.x : head_i.y;
  assign ext_a = SUM_W'(off_a);
  assign ext_b = SUM_W'(off_b);
  assign sum_x = SUM_W'($signed(cx_i)) + (idx_q[0] ? (~ext_a + SUM_W'(1)) : ext_a);
  assign sum_y = SUM_W'($signed(cy_i)) + (idx_q[1] ? (~ext_b + SUM_W'(1)) : ext_b);

  // Output register advances when empty or taken
  assign advance = !out_valid_q || point_o.ready;
  assign load    = advance && head_valid_i;
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = head_valid_i;
    end
    if (load) begin
      idx_d = is_last ? '0 : idx_q + stride;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= sum_x[COORD_WIDTH:0];
      py_q   <= sum_y[COORD_WIDTH:0];
      last_q <= is_last;
      done_q <= is_last && head_i.done;
    end
  end

  assign point_o.valid        = out_valid_q;
  assign point_o.point_x      = px_q;
  assign point_o.point_y      = py_q;
  assign point_o.last_of_step = last_q;
  assign point_o.circle_done  = done_q;

  `MCR_ASSERT(a_done_is_last, (point_o.valid && point_o.circle_done) |-> point_o.last_of_step, "circle_done without last_of_step")
  `MCR_ASSERT(a_idx_bound, head_valid_i |-> idx_q <= last_idx, "point index past end of iteration")
  `MCR_ASSERT(a_pop_marks_last, pop_o |=> (point_o.valid && point_o.last_of_step), "pop without final point")

endmodule

// ===== rtl/midpoint_circle_rasterizer.sv =====
`timescale 1ns / 1ps
// First point of a request: registered in the iteration queue, then in the output register.
// Throughput: one point per cycle while point_o.ready holds; an iteration gives 1, 4 or 8
// points, set by the point sequencer, and requests are taken while a two-deep queue has room.
// Reset (rst_ni low, asynchronous): idle, no circle in progress, queue and output empty.
module midpoint_circle_rasterizer #(
  parameter int COORD_WIDTH = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcr_in_if.sink     item_i,
  mcr_out_if.source  point_o
);

  localparam int JOB_W = 2 * COORD_WIDTH + $bits(mcr_pkg::step_t);

  logic                          push, pop, full, head_valid;
  mcr_pkg::step_t                step, head_step;
  logic signed [COORD_WIDTH-1:0] cx, cy, head_cx, head_cy;
  logic [JOB_W-1:0]              job_in, job_out;

  // Front: state and classification
  mcr_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .step_o (step),
    .cx_o   (cx),
    .cy_o   (cy)
  );

  assign job_in = {cx, cy, step};

  // Queue of pending iterations
  mcr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (mcr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .data_o  (job_out)
  );

  assign head_cx   = job_out[JOB_W-1 -: COORD_WIDTH];
  assign head_cy   = job_out[JOB_W-COORD_WIDTH-1 -: COORD_WIDTH];
  assign head_step = job_out[$bits(mcr_pkg::step_t)-1:0];

  // Back: point sequencer and output register
  mcr_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_step),
    .cx_i         (head_cx),
    .cy_i         (head_cy),
    .pop_o        (pop),
    .point_o      (point_o)
  );

endmodule
